[hdl/assert_macros.svh]
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DCFIR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dcfir assertion failed");

// Condition must never be true outside reset.
`define DCFIR_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("dcfir forbidden condition seen");

`endif

[hdl/dcfir_pkg.sv]
// Types, constants and coefficient table of the dual-channel low-pass FIR.
package dcfir_pkg;

  localparam int TAP_COUNT    = 51;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int COEF_FRAC    = COEF_WIDTH - 1;
  localparam int OUT_WIDTH    = 16;
  localparam int TAP_IDX_W    = $clog2(TAP_COUNT);
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH    = PROD_WIDTH + TAP_IDX_W;

  typedef logic [TAP_IDX_W-1:0] tap_idx_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [ACC_WIDTH-1:0] acc_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] ac_red;
    logic signed [SAMPLE_WIDTH-1:0] ac_infrared;
    logic signed [SAMPLE_WIDTH-1:0] dc_red;
    logic signed [SAMPLE_WIDTH-1:0] dc_infrared;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] filtered_red;
    logic signed [OUT_WIDTH-1:0] filtered_infrared;
    logic signed [OUT_WIDTH-1:0] dc_red_out;
    logic signed [OUT_WIDTH-1:0] dc_infrared_out;
  } out_item_t;

  // Sequencer to lane controls.
  typedef struct packed {
    logic     start;     // clear accumulator
    logic     wr_en;
    tap_idx_t wr_addr;
    logic     rd_en;
    tap_idx_t rd_addr;
    tap_idx_t coef_idx;
    logic     hit;       // read data slot was written since reset
    logic     data_vld;  // read data register holds a tap
    logic     prod_vld;  // product register holds a tap
  } lane_ctrl_t;

  // Q0.15 taps, symmetric, sum is exactly 32768.
  localparam coef_t LP_COEF [TAP_COUNT] = '{
    16'sd0,    16'sd5,    16'sd13,   16'sd23,   16'sd39,   16'sd61,   16'sd91,
    16'sd131,  16'sd180,  16'sd240,  16'sd312,  16'sd393,  16'sd485,  16'sd585,
    16'sd691,  16'sd801,  16'sd914,  16'sd1025, 16'sd1133, 16'sd1234, 16'sd1325,
    16'sd1403, 16'sd1467, 16'sd1514, 16'sd1543, 16'sd1552, 16'sd1543, 16'sd1514,
    16'sd1467, 16'sd1403, 16'sd1325, 16'sd1234, 16'sd1133, 16'sd1025, 16'sd914,
    16'sd801,  16'sd691,  16'sd585,  16'sd485,  16'sd393,  16'sd312,  16'sd240,
    16'sd180,  16'sd131,  16'sd91,   16'sd61,   16'sd39,   16'sd23,   16'sd13,
    16'sd5,    16'sd0
  };

  function automatic coef_t lp_coef(tap_idx_t idx);
    coef_t c;
    c = '0;
    if (idx < TAP_IDX_W'(TAP_COUNT)) begin
      c = LP_COEF[idx];
    end
    return c;
  endfunction

endpackage

[hdl/dcfir_ctrl.sv]
// Tap sequencer: write position, history valid bits and lane control.
`include "assert_macros.svh"

module dcfir_ctrl
  import dcfir_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       merge_ready_i,
  output logic       merge_load_o,
  output lane_ctrl_t lane_ctrl_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  localparam tap_idx_t LAST = TAP_IDX_W'(TAP_COUNT - 1);

  logic [1:0]           state_q, state_d;
  tap_idx_t             pos_q, pos_d;
  tap_idx_t             addr_q, addr_d;
  tap_idx_t             tap_q, tap_d;
  logic [TAP_COUNT-1:0] valid_q, valid_d;
  logic                 data_vld_q, prod_vld_q, hit_q, hit_d;
  logic                 accept, rd_en, drained, load;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign rd_en   = (state_q == S_RUN);
  assign drained = !data_vld_q && !prod_vld_q;
  assign load    = (state_q == S_FLUSH) && drained && merge_ready_i;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    addr_d  = addr_q;
    tap_d   = tap_q;
    valid_d = valid_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d         = S_RUN;
          addr_d          = pos_q;
          tap_d           = '0;
          pos_d           = (pos_q == LAST) ? '0 : pos_q + 1'b1;
          valid_d[pos_q]  = 1'b1;
        end
      end
      S_RUN: begin
        // walk back through history, newest sample first
        addr_d = (addr_q == '0) ? LAST : addr_q - 1'b1;
        tap_d  = tap_q + 1'b1;
        if (tap_q == LAST) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign hit_d = rd_en ? valid_q[addr_q] : hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pos_q      <= '0;
      addr_q     <= '0;
      tap_q      <= '0;
      valid_q    <= '0;
      data_vld_q <= 1'b0;
      prod_vld_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      addr_q     <= addr_d;
      tap_q      <= tap_d;
      valid_q    <= valid_d;
      data_vld_q <= rd_en;
      prod_vld_q <= data_vld_q;
      hit_q      <= hit_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign merge_load_o = load;

  assign lane_ctrl_o.start    = accept;
  assign lane_ctrl_o.wr_en    = accept;
  assign lane_ctrl_o.wr_addr  = pos_q;
  assign lane_ctrl_o.rd_en    = rd_en;
  assign lane_ctrl_o.rd_addr  = addr_q;
  assign lane_ctrl_o.coef_idx = tap_q;
  assign lane_ctrl_o.hit      = hit_q;
  assign lane_ctrl_o.data_vld = data_vld_q;
  assign lane_ctrl_o.prod_vld = prod_vld_q;

  `DCFIR_ASSERT_NEVER(a_pos_range, clk_i, rst_ni, pos_q > LAST)
  `DCFIR_ASSERT(a_slot_marked, clk_i, rst_ni, accept |=> valid_q[$past(pos_q)])
  `DCFIR_ASSERT(a_walk_start, clk_i, rst_ni, accept |=> (addr_q == $past(pos_q)))

endmodule

[hdl/dcfir_lane.sv]
// One filter lane: sample history memory and multiply-accumulate.
module dcfir_lane
  import dcfir_pkg::*;
(
  input  logic       clk_i,
  input  lane_ctrl_t ctrl_i,
  input  sample_t    sample_i,
  output acc_t       acc_o
);

  sample_t                      hist_mem [TAP_COUNT];
  sample_t                      rd_data_q;
  coef_t                        coef_q;
  logic signed [PROD_WIDTH-1:0] prod_q;
  acc_t                         acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      hist_mem[ctrl_i.wr_addr] <= sample_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= hist_mem[ctrl_i.rd_addr];
      coef_q    <= lp_coef(ctrl_i.coef_idx);
    end
  end

  // slots never written since reset count as zero
  always_ff @(posedge clk_i) begin
    if (ctrl_i.data_vld) begin
      prod_q <= ctrl_i.hit ? PROD_WIDTH'(rd_data_q) * PROD_WIDTH'(coef_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (ctrl_i.prod_vld) begin
      acc_q <= acc_q + ACC_WIDTH'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule

[hdl/dcfir_merge.sv]
// Merge stage: rounds and saturates both lane sums, holds the result item.
`include "assert_macros.svh"

module dcfir_merge
  import dcfir_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  in_data_i,
  input  logic      load_i,
  input  acc_t      acc_red_i,
  input  acc_t      acc_infrared_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam acc_t ROUND_BIAS = ACC_WIDTH'(1) <<< (COEF_FRAC - 1);
  localparam acc_t OUT_MAX    = ACC_WIDTH'((2 ** (OUT_WIDTH - 1)) - 1);
  localparam acc_t OUT_MIN    = ACC_WIDTH'(-(2 ** (OUT_WIDTH - 1)));

  function automatic logic signed [OUT_WIDTH-1:0] round_sat(acc_t acc);
    acc_t q;
    logic signed [OUT_WIDTH-1:0] r;
    q = (acc + ROUND_BIAS) >>> COEF_FRAC;
    if (q > OUT_MAX) begin
      r = OUT_MAX[OUT_WIDTH-1:0];
    end else if (q < OUT_MIN) begin
      r = OUT_MIN[OUT_WIDTH-1:0];
    end else begin
      r = q[OUT_WIDTH-1:0];
    end
    return r;
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] dc_red_q, dc_infrared_q;
  out_item_t                      out_q;
  logic                           out_valid_q;

  assign ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dc_red_q      <= in_data_i.dc_red;
      dc_infrared_q <= in_data_i.dc_infrared;
    end
    if (load_i) begin
      out_q.filtered_red      <= round_sat(acc_red_i);
      out_q.filtered_infrared <= round_sat(acc_infrared_i);
      out_q.dc_red_out        <= dc_red_q;
      out_q.dc_infrared_out   <= dc_infrared_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DCFIR_ASSERT(a_load_room, clk_i, rst_ni, load_i |-> ready_o)
  `DCFIR_ASSERT(a_load_shows, clk_i, rst_ni, load_i |=> out_valid_q)

endmodule

[hdl/dual_channel_fir_lowpass.sv]
// The result item is loaded once both lanes have drained and the output register is free.
// Each lane walks 51 taps through its history read port and one multiply-accumulate, plus read,
// product and merge stages; no new item is accepted until the result has been loaded.
// Reset: position returns to slot 0 and all history valid bits clear, so history reads as zero;
// no clearing pass, the block takes an item in the first cycle after reset.
module dual_channel_fir_lowpass
  import dcfir_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  lane_ctrl_t lane_ctrl;
  logic       merge_ready, merge_load;
  acc_t       acc_red, acc_infrared;

  dcfir_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .merge_ready_i (merge_ready),
    .merge_load_o  (merge_load),
    .lane_ctrl_o   (lane_ctrl)
  );

  dcfir_lane u_lane_red (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .sample_i (in_data_i.ac_red),
    .acc_o    (acc_red)
  );

  dcfir_lane u_lane_infrared (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .sample_i (in_data_i.ac_infrared),
    .acc_o    (acc_infrared)
  );

  dcfir_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (lane_ctrl.start),
    .in_data_i      (in_data_i),
    .load_i         (merge_load),
    .acc_red_i      (acc_red),
    .acc_infrared_i (acc_infrared),
    .ready_o        (merge_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the dual-channel 51-tap low-pass FIR.
module testbench
  import dcfir_pkg::*;
();

  localparam int NUM_TAPS       = 51;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  // Q0.15 low-pass taps, symmetric, summing to 32768
  localparam int TAP_WEIGHT [NUM_TAPS] = '{
       0,    5,   13,   23,   39,   61,   91,  131,  180,  240,
     312,  393,  485,  585,  691,  801,  914, 1025, 1133, 1234,
    1325, 1403, 1467, 1514, 1543, 1552, 1543, 1514, 1467, 1403,
    1325, 1234, 1133, 1025,  914,  801,  691,  585,  485,  393,
     312,  240,  180,  131,   91,   61,   39,   23,   13,    5,
       0
  };

  typedef enum int {SEG_NOISE, SEG_PLATEAU, SEG_TOGGLE, SEG_WIGGLE} segment_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  bit        no_idle = 1'b0;
  int        error_count = 0;
  out_item_t expected_outputs [$];

  logic signed [SAMPLE_WIDTH-1:0] red_taps      [NUM_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] infrared_taps [NUM_TAPS];
  int                             tap_slot;

  dual_channel_fir_lowpass dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [OUT_WIDTH-1:0] round_saturate(input longint acc);
    longint q;
    q = (acc + 64'sd16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[OUT_WIDTH-1:0];
  endfunction

  // Writes the new samples into the history and filters both AC channels.
  function automatic out_item_t lowpass_step(input in_item_t s);
    out_item_t r;
    longint    red_acc;
    longint    ir_acc;
    int        idx;
    red_taps[tap_slot]      = s.ac_red;
    infrared_taps[tap_slot] = s.ac_infrared;
    red_acc = 0;
    ir_acc  = 0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      idx = (tap_slot + NUM_TAPS - i) % NUM_TAPS;
      red_acc += longint'(TAP_WEIGHT[i]) * longint'(red_taps[idx]);
      ir_acc  += longint'(TAP_WEIGHT[i]) * longint'(infrared_taps[idx]);
    end
    r.filtered_red      = round_saturate(red_acc);
    r.filtered_infrared = round_saturate(ir_acc);
    r.dc_red_out        = s.dc_red;
    r.dc_infrared_out   = s.dc_infrared;
    tap_slot = (tap_slot + 1) % NUM_TAPS;
    return r;
  endfunction

  function automatic in_item_t make_sample(input logic [15:0] r, ir, dr, di);
    in_item_t s;
    s = {r, ir, dr, di};
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Leaves valid high on return so a zero gap gives back-to-back items.
  task automatic send_sample(input in_item_t s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    expected_outputs.push_back(lowpass_step(s));
  endtask

  initial begin : result_checker
    int        hold;
    out_item_t want;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        // stall until a result shows up, then keep it waiting
        out_stall_i <= 1'b1;
        do @(posedge clk_i); while (out_valid_o !== 1'b1);
        repeat (hold - 1) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (expected_outputs.size() == 0) begin
        report_mismatch("unexpected result, filtered_red", int'(out_data_o.filtered_red), 0);
      end else begin
        want = expected_outputs.pop_front();
        if (out_data_o.filtered_red !== want.filtered_red)
          report_mismatch("filtered_red", int'(out_data_o.filtered_red),
                          int'(want.filtered_red));
        if (out_data_o.filtered_infrared !== want.filtered_infrared)
          report_mismatch("filtered_infrared", int'(out_data_o.filtered_infrared),
                          int'(want.filtered_infrared));
        if (out_data_o.dc_red_out !== want.dc_red_out)
          report_mismatch("dc_red_out", int'(out_data_o.dc_red_out), int'(want.dc_red_out));
        if (out_data_o.dc_infrared_out !== want.dc_infrared_out)
          report_mismatch("dc_infrared_out", int'(out_data_o.dc_infrared_out),
                          int'(want.dc_infrared_out));
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Start-up ramp: an extreme impulse into empty history, then silence.
  task automatic test_impulse_response();
    send_sample(make_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    repeat (4) send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'hffff));
  endtask

  task automatic test_alternating_extremes();
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0) send_sample(make_sample(16'h7fff, 16'h8000, 16'h0000, 16'h0000));
      else            send_sample(make_sample(16'h8000, 16'h7fff, 16'h0000, 16'h0000));
    end
  endtask

  task automatic test_dc_passthrough();
    send_sample(make_sample(16'($urandom), 16'($urandom), 16'h8000, 16'h7fff));
    send_sample(make_sample(16'($urandom), 16'($urandom), 16'h7fff, 16'h8000));
    send_sample(make_sample(16'($urandom), 16'($urandom), 16'hffff, 16'h0000));
    send_sample(make_sample(16'($urandom), 16'($urandom), 16'h0000, 16'hffff));
    send_sample(make_sample(16'($urandom), 16'($urandom), 16'h5555, 16'haaaa));
    send_sample(make_sample(16'($urandom), 16'($urandom), 16'haaaa, 16'h5555));
  endtask

  // Mixed segments: noise, full-history plateaus at the limits, toggling, small wiggle.
  task automatic test_random_segments(input int count);
    segment_e    kind;
    int          len;
    int          sent;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] level;
    sent = 0;
    while (sent < count) begin
      kind = segment_e'($urandom_range(0, 3));
      case (kind)
        SEG_NOISE: begin
          len = $urandom_range(10, 40);
          for (int k = 0; k < len; k++) send_sample(in_item_t'({$urandom, $urandom}));
        end
        SEG_PLATEAU: begin
          len = $urandom_range(51, 60);
          a = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          b = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          for (int k = 0; k < len; k++)
            send_sample(make_sample(a, b, 16'($urandom), 16'($urandom)));
        end
        SEG_TOGGLE: begin
          len = 20;
          for (int k = 0; k < len; k++) begin
            a = (k % 2) ? 16'h8000 : 16'h7fff;
            send_sample(make_sample(a, ~a, 16'($urandom), 16'($urandom)));
          end
        end
        default: begin
          len = $urandom_range(10, 30);
          level = 16'($urandom);
          for (int k = 0; k < len; k++) begin
            a = level + 16'($urandom_range(0, 127)) - 16'd64;
            b = level - 16'($urandom_range(0, 127)) + 16'd64;
            send_sample(make_sample(a, b, 16'($urandom), 16'($urandom)));
          end
        end
      endcase
      sent += len;
    end
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    for (int k = 0; k < count; k++) send_sample(in_item_t'({$urandom, $urandom}));
    no_idle = 1'b0;
  endtask

  // Sender holds off until the filter has returned everything, then resumes.
  task automatic test_drain_pause();
    for (int k = 0; k < 10; k++) send_sample(in_item_t'({$urandom, $urandom}));
    in_valid_i <= 1'b0;
    while (expected_outputs.size() > 0) @(posedge clk_i);
    for (int k = 0; k < 10; k++) send_sample(in_item_t'({$urandom, $urandom}));
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    tap_slot = 0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      red_taps[i]      = '0;
      infrared_taps[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_impulse_response();
    test_alternating_extremes();
    test_dc_passthrough();
    test_back_to_back(60);
    test_random_segments(370);
    test_drain_pause();
    test_random_segments(380);

    in_valid_i <= 1'b0;
    while (expected_outputs.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/dcfir_pkg.sv
hdl/dcfir_ctrl.sv
hdl/dcfir_lane.sv
hdl/dcfir_merge.sv
hdl/dual_channel_fir_lowpass.sv
sim/testbench.sv
